// ----- rtl/core/fars_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fars_pkg
// shared types, codes and constants of the flagged alu register step block
// ----------------------------------------------------------------------------
package fars_pkg;

  localparam int DATA_W   = 64;
  localparam int IDX_W    = 4;
  localparam int NUM_REGS = 16;
  localparam int REG_AW   = $clog2(NUM_REGS);

  localparam logic [IDX_W-1:0]  STATE_REG  = IDX_W'(15);
  localparam logic [IDX_W-1:0]  RESULT_REG = IDX_W'(0);
  localparam logic [DATA_W-1:0] SIGN_BIT   = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [4:0] {
    FUNC_NOP      = 5'd0,
    FUNC_MOV      = 5'd1,
    FUNC_ADD      = 5'd2,
    FUNC_SUB      = 5'd3,
    FUNC_MUL      = 5'd4,
    FUNC_IMUL     = 5'd5,
    FUNC_XOR      = 5'd6,
    FUNC_AND      = 5'd7,
    FUNC_OR       = 5'd8,
    FUNC_NOT      = 5'd9,
    FUNC_NEG      = 5'd10,
    FUNC_SHL      = 5'd11,
    FUNC_SHR      = 5'd12,
    FUNC_XCHG     = 5'd13,
    FUNC_CMP      = 5'd14,
    FUNC_TEST     = 5'd15,
    FUNC_INC      = 5'd16,
    FUNC_DEC      = 5'd17,
    FUNC_JMP      = 5'd18,
    FUNC_JE       = 5'd19,
    FUNC_JNE      = 5'd20,
    FUNC_JL       = 5'd21,
    FUNC_JG       = 5'd22,
    FUNC_JLE      = 5'd23,
    FUNC_JGE      = 5'd24,
    FUNC_RET      = 5'd25,
    FUNC_STATEMOV = 5'd26,
    FUNC_STATECMP = 5'd27,
    FUNC_START    = 5'd28
  } func_t;

  typedef enum logic [1:0] {
    KIND_REG  = 2'd0,
    KIND_IMM  = 2'd1,
    KIND_NONE = 2'd2
  } kind_t;

  typedef struct packed {
    logic z;
    logic s;
    logic c;
    logic o;
    logic p;
  } flags_t;

  typedef struct packed {
    func_t              func;
    kind_t              dst_kind;
    logic [IDX_W-1:0]   dst_index;
    logic [DATA_W-1:0]  dst_value;
    kind_t              src_kind;
    logic [IDX_W-1:0]   src_index;
    logic [DATA_W-1:0]  src_value;
  } instr_t;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] data;
  } wr_port_t;

  function automatic logic in_range(input logic [IDX_W-1:0] idx);
    return ({1'b0, idx} < (IDX_W+1)'(NUM_REGS));
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/fars_regfile.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fars_regfile
// general register file: two read ports, two write ports, whole-file clear
// ----------------------------------------------------------------------------
module fars_regfile import fars_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              clear,
  input  wire wr_port_t          wr_a,
  input  wire wr_port_t          wr_b,
  input  wire logic [IDX_W-1:0]  rd_a_idx,
  input  wire logic [IDX_W-1:0]  rd_b_idx,
  output logic [DATA_W-1:0]      rd_a_data,
  output logic [DATA_W-1:0]      rd_b_data,
  output logic [DATA_W-1:0]      state_data,
  output logic [DATA_W-1:0]      result_next
);

  logic [DATA_W-1:0] regs      [NUM_REGS];
  logic [DATA_W-1:0] regs_next [NUM_REGS];

  assign rd_a_data   = in_range(rd_a_idx) ? regs[rd_a_idx[REG_AW-1:0]] : '0;
  assign rd_b_data   = in_range(rd_b_idx) ? regs[rd_b_idx[REG_AW-1:0]] : '0;
  assign state_data  = in_range(STATE_REG) ? regs[STATE_REG[REG_AW-1:0]] : '0;
  assign result_next = in_range(RESULT_REG) ? regs_next[RESULT_REG[REG_AW-1:0]] : '0;

  // port b is the later write of an exchange, so it wins
  always_comb begin
    for (int i = 0; i < NUM_REGS; i++) begin
      regs_next[i] = clear ? '0 : regs[i];
    end
    if (wr_a.en) begin
      regs_next[wr_a.idx[REG_AW-1:0]] = wr_a.data;
    end
    if (wr_b.en) begin
      regs_next[wr_b.idx[REG_AW-1:0]] = wr_b.data;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_REGS; i++) begin
      if (rst) begin
        regs[i] <= '0;
      end else begin
        regs[i] <= regs_next[i];
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/fars_exec.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fars_exec
// execute logic: operand select, adder, multiplier, logic ops, shifter,
// flag rules, branch conditions and register write requests
// ----------------------------------------------------------------------------
module fars_exec import fars_pkg::*; (
  input  wire instr_t             instr,
  input  wire logic [DATA_W-1:0]  rd_a_data,
  input  wire logic [DATA_W-1:0]  rd_b_data,
  input  wire logic [DATA_W-1:0]  state_data,
  input  wire flags_t             flags,
  output wr_port_t                wr_a,
  output wr_port_t                wr_b,
  output logic                    clear,
  output flags_t                  flags_next,
  output logic                    taken,
  output logic                    halt
);

  logic [DATA_W-1:0] a;
  logic [DATA_W-1:0] b;
  logic [DATA_W-1:0] x;
  logic [DATA_W-1:0] y;
  logic              sub;
  logic [DATA_W:0]   sum;
  logic [DATA_W-1:0] r_arith;
  logic              cf;
  logic              of;
  logic [DATA_W-1:0] p_ll;
  logic [DATA_W-1:0] p_lh;
  logic [DATA_W-1:0] p_hl;
  logic [DATA_W-1:0] r_mul;
  logic [DATA_W-1:0] res;
  logic [DATA_W-1:0] fr;
  logic              dst_wr;
  logic              fz;
  logic              fs;
  logic              fp;
  flags_t            f_full;
  flags_t            f_logic;

  always_comb begin
    case (instr.dst_kind)
      KIND_REG: a = rd_a_data;
      KIND_IMM: a = instr.dst_value;
      default:  a = '0;
    endcase
    case (instr.src_kind)
      KIND_REG: b = rd_b_data;
      KIND_IMM: b = instr.src_value;
      default:  b = '0;
    endcase
  end

  // one shared add/subtract unit
  always_comb begin
    x   = a;
    y   = b;
    sub = 1'b0;
    case (instr.func)
      FUNC_SUB, FUNC_CMP: sub = 1'b1;
      FUNC_NEG: begin
        x   = '0;
        y   = a;
        sub = 1'b1;
      end
      FUNC_STATECMP: begin
        x   = state_data;
        sub = 1'b1;
      end
      FUNC_INC: y = DATA_W'(1);
      FUNC_DEC: begin
        y   = DATA_W'(1);
        sub = 1'b1;
      end
      default: ;
    endcase
  end

  assign sum     = {1'b0, x} + {1'b0, (sub ? ~y : y)} + (DATA_W+1)'(sub);
  assign r_arith = sum[DATA_W-1:0];
  assign cf      = sub ? ~sum[DATA_W] : sum[DATA_W];
  assign of      = sub ? |((x ^ y) & (x ^ r_arith) & SIGN_BIT)
                       : |(~(x ^ y) & (x ^ r_arith) & SIGN_BIT);

  // low half of the product from three 32x32 partial products
  assign p_ll  = a[31:0] * b[31:0];
  assign p_lh  = a[31:0] * b[63:32];
  assign p_hl  = a[63:32] * b[31:0];
  assign r_mul = p_ll + {p_lh[31:0] + p_hl[31:0], 32'd0};

  assign fz      = (fr == '0);
  assign fs      = fr[DATA_W-1];
  assign fp      = ~^fr[7:0];
  assign f_full  = '{z: fz, s: fs, c: cf, o: of, p: fp};
  assign f_logic = '{z: fz, s: fs, c: 1'b0, o: 1'b0, p: fp};

  always_comb begin
    res        = '0;
    fr         = r_arith;
    dst_wr     = 1'b0;
    flags_next = flags;
    taken      = 1'b0;
    halt       = 1'b0;
    clear      = 1'b0;
    wr_b       = '{en: 1'b0, idx: instr.src_index, data: a};
    case (instr.func)
      FUNC_MOV: begin
        res    = b;
        dst_wr = 1'b1;
      end
      FUNC_ADD, FUNC_SUB, FUNC_NEG: begin
        res        = r_arith;
        dst_wr     = 1'b1;
        flags_next = f_full;
      end
      FUNC_MUL, FUNC_IMUL: begin
        res    = r_mul;
        dst_wr = 1'b1;
      end
      FUNC_XOR: begin
        res        = a ^ b;
        fr         = res;
        dst_wr     = 1'b1;
        flags_next = f_logic;
      end
      FUNC_AND: begin
        res        = a & b;
        fr         = res;
        dst_wr     = 1'b1;
        flags_next = f_logic;
      end
      FUNC_OR: begin
        res        = a | b;
        fr         = res;
        dst_wr     = 1'b1;
        flags_next = f_logic;
      end
      FUNC_NOT: begin
        res    = ~a;
        dst_wr = 1'b1;
      end
      FUNC_SHL: begin
        res          = a << b[5:0];
        fr           = res;
        dst_wr       = 1'b1;
        flags_next.z = fz;
        flags_next.s = fs;
      end
      FUNC_SHR: begin
        res          = a >> b[5:0];
        fr           = res;
        dst_wr       = 1'b1;
        flags_next.z = fz;
        flags_next.s = fs;
      end
      FUNC_XCHG: begin
        res     = b;
        dst_wr  = 1'b1;
        wr_b.en = (instr.src_kind == KIND_REG) && in_range(instr.src_index);
      end
      FUNC_CMP, FUNC_STATECMP: flags_next = f_full;
      FUNC_TEST: begin
        fr         = a & b;
        flags_next = f_logic;
      end
      FUNC_INC, FUNC_DEC: begin
        res          = r_arith;
        dst_wr       = 1'b1;
        flags_next.z = fz;
        flags_next.s = fs;
        flags_next.o = of;
      end
      FUNC_JMP: taken = 1'b1;
      FUNC_JE:  taken = flags.z;
      FUNC_JNE: taken = ~flags.z;
      FUNC_JL:  taken = flags.s ^ flags.o;
      FUNC_JG:  taken = ~flags.z & ~(flags.s ^ flags.o);
      FUNC_JLE: taken = flags.z | (flags.s ^ flags.o);
      FUNC_JGE: taken = ~(flags.s ^ flags.o);
      FUNC_RET: halt = 1'b1;
      FUNC_STATEMOV: res = b;
      FUNC_START: begin
        res        = instr.src_value;
        clear      = 1'b1;
        flags_next = '0;
      end
      default: ;
    endcase
  end

  // statemov and start write fixed registers regardless of operand kind
  always_comb begin
    case (instr.func)
      FUNC_STATEMOV: wr_a = '{en: in_range(STATE_REG), idx: STATE_REG, data: res};
      FUNC_START:    wr_a = '{en: in_range(RESULT_REG), idx: RESULT_REG, data: res};
      default: begin
        wr_a = '{en: dst_wr && (instr.dst_kind == KIND_REG) && in_range(instr.dst_index),
                 idx: instr.dst_index, data: res};
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/core/flagged_alu_register_step.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flagged_alu_register_step
// single-issue execute stage: one decoded instruction per request against
// sixteen 64-bit registers and the ZF/SF/CF/OF/PF flags
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid/in_stall) carries one decoded instruction per
//   request; output channel (out_valid/out_stall) returns one result per
//   instruction: branch taken, halted, R0 and the five flags after the step.
//   a request lands in an input register; when the result register is free the
//   execute logic reads the register file and flags, updates them and fills
//   the result register. throughput is one instruction per cycle while the
//   receiver does not stall, set by the single execute pass that reads and
//   writes the register file in the same cycle.
//   when the receiver stalls, the finished result holds in the output
//   register, one more instruction waits in the input register, and then
//   in_stall rises; nothing executes until the result is taken.
//   reset clears both channels, all registers and flags; a start
//   instruction does the same to registers and flags and loads R0.
// ----------------------------------------------------------------------------
module flagged_alu_register_step import fars_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [4:0]        func,
  input  wire logic [1:0]        dst_kind,
  input  wire logic [IDX_W-1:0]  dst_index,
  input  wire logic [DATA_W-1:0] dst_value,
  input  wire logic [1:0]        src_kind,
  input  wire logic [IDX_W-1:0]  src_index,
  input  wire logic [DATA_W-1:0] src_value,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   branch_taken,
  output logic                   halted,
  output logic [DATA_W-1:0]      reg_zero_value,
  output logic                   zero_flag,
  output logic                   sign_flag,
  output logic                   carry_flag,
  output logic                   overflow_flag,
  output logic                   parity_flag
);

  instr_t            stage;
  logic              stage_valid;
  logic              fire;
  logic              accept;
  flags_t            flags;
  flags_t            flags_next;
  wr_port_t          ex_wr_a;
  wr_port_t          ex_wr_b;
  wr_port_t          wr_a;
  wr_port_t          wr_b;
  logic              ex_clear;
  logic              ex_taken;
  logic              ex_halt;
  logic [DATA_W-1:0] rd_a_data;
  logic [DATA_W-1:0] rd_b_data;
  logic [DATA_W-1:0] state_data;
  logic [DATA_W-1:0] result_next;

  assign fire     = stage_valid && (!out_valid || !out_stall);
  assign in_stall = stage_valid && !fire;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= 1'b1;
    end else if (fire) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage <= '{func: func_t'(func), dst_kind: kind_t'(dst_kind), dst_index: dst_index,
                 dst_value: dst_value, src_kind: kind_t'(src_kind),
                 src_index: src_index, src_value: src_value};
    end
  end

  fars_exec u_exec (
    .instr      (stage),
    .rd_a_data  (rd_a_data),
    .rd_b_data  (rd_b_data),
    .state_data (state_data),
    .flags      (flags),
    .wr_a       (ex_wr_a),
    .wr_b       (ex_wr_b),
    .clear      (ex_clear),
    .flags_next (flags_next),
    .taken      (ex_taken),
    .halt       (ex_halt)
  );

  // state changes only when the instruction actually retires
  always_comb begin
    wr_a    = ex_wr_a;
    wr_b    = ex_wr_b;
    wr_a.en = ex_wr_a.en && fire;
    wr_b.en = ex_wr_b.en && fire;
  end

  fars_regfile u_regfile (
    .clk         (clk),
    .rst         (rst),
    .clear       (ex_clear && fire),
    .wr_a        (wr_a),
    .wr_b        (wr_b),
    .rd_a_idx    (stage.dst_index),
    .rd_b_idx    (stage.src_index),
    .rd_a_data   (rd_a_data),
    .rd_b_data   (rd_b_data),
    .state_data  (state_data),
    .result_next (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
    end else if (fire) begin
      flags <= flags_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      branch_taken   <= ex_taken;
      halted         <= ex_halt;
      reg_zero_value <= result_next;
      zero_flag      <= flags_next.z;
      sign_flag      <= flags_next.s;
      carry_flag     <= flags_next.c;
      overflow_flag  <= flags_next.o;
      parity_flag    <= flags_next.p;
    end
  end

endmodule
`default_nettype wire

// ----- sim/flagged_alu_register_step_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flagged_alu_register_step_tb
// drives decoded instructions into the execute stage with random gaps and
// output stalls, keeps its own register file and flags, and compares every
// result (branch taken, halted, R0, five flags) to that prediction or a row's
// own expectation; directed table rows run first, then random traffic
// ----------------------------------------------------------------------------
module flagged_alu_register_step_tb;
  import fars_pkg::*;

  localparam int CLK_PERIOD     = 20;
  localparam int RESET_CYCLES   = 12;
  localparam int RANDOM_ITEMS   = 1650;
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 2000;

  localparam logic [DATA_W-1:0] MIN_SIGNED = SIGN_BIT;
  localparam logic [DATA_W-1:0] MAX_SIGNED = ~SIGN_BIT;
  localparam logic [1:0]        KIND_SPARE    = 2'd3;
  localparam logic [4:0]        FUNC_SPARE_LO = 5'd29;
  localparam logic [4:0]        FUNC_SPARE_HI = 5'd31;

  typedef struct packed {
    logic              taken;
    logic              halt;
    logic [DATA_W-1:0] r0;
    flags_t            fl;
  } step_result_t;

  typedef struct packed {
    logic [4:0]        func;
    logic [1:0]        dk;
    logic [IDX_W-1:0]  di;
    logic [DATA_W-1:0] dv;
    logic [1:0]        sk;
    logic [IDX_W-1:0]  si;
    logic [DATA_W-1:0] sv;
    logic              has_exp;
    step_result_t      exp;
  } instr_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic out_stall = 1'b0;
  instr_row_t cur_row = '0;

  logic              in_stall;
  logic [4:0]        func;
  logic [1:0]        dst_kind;
  logic [IDX_W-1:0]  dst_index;
  logic [DATA_W-1:0] dst_value;
  logic [1:0]        src_kind;
  logic [IDX_W-1:0]  src_index;
  logic [DATA_W-1:0] src_value;
  logic              out_valid;
  logic              branch_taken;
  logic              halted;
  logic [DATA_W-1:0] reg_zero_value;
  logic              zero_flag;
  logic              sign_flag;
  logic              carry_flag;
  logic              overflow_flag;
  logic              parity_flag;

  assign func      = cur_row.func;
  assign dst_kind  = cur_row.dk;
  assign dst_index = cur_row.di;
  assign dst_value = cur_row.dv;
  assign src_kind  = cur_row.sk;
  assign src_index = cur_row.si;
  assign src_value = cur_row.sv;

  flagged_alu_register_step dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .func           (func),
    .dst_kind       (dst_kind),
    .dst_index      (dst_index),
    .dst_value      (dst_value),
    .src_kind       (src_kind),
    .src_index      (src_index),
    .src_value      (src_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .branch_taken   (branch_taken),
    .halted         (halted),
    .reg_zero_value (reg_zero_value),
    .zero_flag      (zero_flag),
    .sign_flag      (sign_flag),
    .carry_flag     (carry_flag),
    .overflow_flag  (overflow_flag),
    .parity_flag    (parity_flag)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // shadow machine state
  logic [DATA_W-1:0] model_regs [NUM_REGS];
  flags_t            model_flags;

  step_result_t expected_results [$];
  instr_row_t   dir_rows [$];
  int           fail_count = 0;
  int           idle_cycles = 0;
  bit           calm = 1'b0;

  initial begin
    foreach (model_regs[i]) model_regs[i] = '0;
    model_flags = '0;
  end

  function automatic logic [DATA_W-1:0] operand_value(input logic [1:0] kind,
                                                      input logic [IDX_W-1:0] idx,
                                                      input logic [DATA_W-1:0] imm);
    if (kind == KIND_REG) return (idx < NUM_REGS) ? model_regs[idx] : '0;
    if (kind == KIND_IMM) return imm;
    return '0;
  endfunction

  function automatic void write_back(input logic [1:0] kind, input logic [IDX_W-1:0] idx,
                                     input logic [DATA_W-1:0] v);
    if (kind == KIND_REG && idx < NUM_REGS) model_regs[idx] = v;
  endfunction

  function automatic flags_t zsp_flags(input logic [DATA_W-1:0] r);
    flags_t f;
    f   = '0;
    f.z = (r == '0);
    f.s = r[DATA_W-1];
    f.p = ~^r[7:0];
    return f;
  endfunction

  function automatic flags_t add_flags(input logic [DATA_W-1:0] a, b, r);
    flags_t f;
    f   = zsp_flags(r);
    f.c = (r < a);
    f.o = (a[DATA_W-1] == b[DATA_W-1]) && (a[DATA_W-1] != r[DATA_W-1]);
    return f;
  endfunction

  function automatic flags_t sub_flags(input logic [DATA_W-1:0] a, b, r);
    flags_t f;
    f   = zsp_flags(r);
    f.c = (a < b);
    f.o = (a[DATA_W-1] != b[DATA_W-1]) && (a[DATA_W-1] != r[DATA_W-1]);
    return f;
  endfunction

  function automatic step_result_t predict_step(input instr_row_t it);
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] r;
    step_result_t res;
    a   = operand_value(it.dk, it.di, it.dv);
    b   = operand_value(it.sk, it.si, it.sv);
    res = '0;
    case (it.func)
      FUNC_MOV: write_back(it.dk, it.di, b);
      FUNC_ADD: begin
        r = a + b;
        write_back(it.dk, it.di, r);
        model_flags = add_flags(a, b, r);
      end
      FUNC_SUB: begin
        r = a - b;
        write_back(it.dk, it.di, r);
        model_flags = sub_flags(a, b, r);
      end
      FUNC_MUL, FUNC_IMUL: write_back(it.dk, it.di, a * b);
      FUNC_XOR: begin
        r = a ^ b;
        write_back(it.dk, it.di, r);
        model_flags = zsp_flags(r);
      end
      FUNC_AND: begin
        r = a & b;
        write_back(it.dk, it.di, r);
        model_flags = zsp_flags(r);
      end
      FUNC_OR: begin
        r = a | b;
        write_back(it.dk, it.di, r);
        model_flags = zsp_flags(r);
      end
      FUNC_NOT: write_back(it.dk, it.di, ~a);
      FUNC_NEG: begin
        r = '0 - a;
        write_back(it.dk, it.di, r);
        model_flags = sub_flags('0, a, r);
      end
      FUNC_SHL, FUNC_SHR: begin
        r = (it.func == FUNC_SHL) ? (a << b[5:0]) : (a >> b[5:0]);
        write_back(it.dk, it.di, r);
        model_flags.z = (r == '0);
        model_flags.s = r[DATA_W-1];
      end
      FUNC_XCHG: begin
        // self exchange: second write wins
        write_back(it.dk, it.di, b);
        write_back(it.sk, it.si, a);
      end
      FUNC_CMP:  model_flags = sub_flags(a, b, a - b);
      FUNC_TEST: model_flags = zsp_flags(a & b);
      FUNC_INC, FUNC_DEC: begin
        r = (it.func == FUNC_INC) ? a + 1'b1 : a - 1'b1;
        write_back(it.dk, it.di, r);
        model_flags.z = (r == '0);
        model_flags.s = r[DATA_W-1];
        model_flags.o = (it.func == FUNC_INC) ? (a == MAX_SIGNED) : (a == MIN_SIGNED);
      end
      FUNC_JMP: res.taken = 1'b1;
      FUNC_JE:  res.taken = model_flags.z;
      FUNC_JNE: res.taken = !model_flags.z;
      FUNC_JL:  res.taken = (model_flags.s != model_flags.o);
      FUNC_JG:  res.taken = !model_flags.z && (model_flags.s == model_flags.o);
      FUNC_JLE: res.taken = model_flags.z || (model_flags.s != model_flags.o);
      FUNC_JGE: res.taken = (model_flags.s == model_flags.o);
      FUNC_RET: res.halt = 1'b1;
      FUNC_STATEMOV: model_regs[STATE_REG] = b;
      FUNC_STATECMP: begin
        r = model_regs[STATE_REG];
        model_flags = sub_flags(r, b, r - b);
      end
      FUNC_START: begin
        foreach (model_regs[i]) model_regs[i] = '0;
        model_flags = '0;
        model_regs[RESULT_REG] = it.sv;
      end
      default: ;
    endcase
    res.r0 = model_regs[RESULT_REG];
    res.fl = model_flags;
    return res;
  endfunction

  function automatic step_result_t result_of(input logic taken, halt,
                                             input logic [DATA_W-1:0] r0,
                                             input logic z, s, c, o, p);
    step_result_t res;
    res.taken = taken;
    res.halt  = halt;
    res.r0    = r0;
    res.fl    = '{z: z, s: s, c: c, o: o, p: p};
    return res;
  endfunction

  task automatic add_row(input logic [4:0] f, input logic [1:0] dk,
                         input logic [IDX_W-1:0] di, input logic [DATA_W-1:0] dv,
                         input logic [1:0] sk, input logic [IDX_W-1:0] si,
                         input logic [DATA_W-1:0] sv, input logic typed,
                         input step_result_t e);
    instr_row_t row;
    row = '{func: f, dk: dk, di: di, dv: dv, sk: sk, si: si, sv: sv,
            has_exp: typed, exp: e};
    dir_rows.push_back(row);
  endtask

  function automatic int pick_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (calm || p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [DATA_W-1:0] rand_value();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 15) begin
      case ($urandom_range(0, 4))
        0: return '0;
        1: return 1;
        2: return '1;
        3: return MAX_SIGNED;
        default: return MIN_SIGNED;
      endcase
    end
    // small values exercise shift counts and near-zero arithmetic
    if (p < 35) return DATA_W'($urandom_range(0, 70));
    if (p < 45) return '0 - DATA_W'($urandom_range(1, 70));
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [1:0] rand_kind(input int unsigned reg_pct);
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < reg_pct) return KIND_REG;
    if (p < 90) return KIND_IMM;
    if (p < 97) return KIND_NONE;
    return KIND_SPARE;
  endfunction

  function automatic logic [IDX_W-1:0] rand_index();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 25) return RESULT_REG;
    if (p < 35) return STATE_REG;
    return IDX_W'($urandom_range(0, NUM_REGS - 1));
  endfunction

  task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      fail_count++;
    end
  endtask

  // request and result bookkeeping in one process so ordering within an edge is fixed
  always @(posedge clk) begin
    step_result_t pred;
    step_result_t want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        pred = predict_step(cur_row);
        expected_results.push_back(cur_row.has_exp ? cur_row.exp : pred);
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding");
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("branch_taken", want.taken, branch_taken);
          check_field("halted", want.halt, halted);
          check_field("reg_zero_value", want.r0, reg_zero_value);
          check_field("zero_flag", want.fl.z, zero_flag);
          check_field("sign_flag", want.fl.s, sign_flag);
          check_field("carry_flag", want.fl.c, carry_flag);
          check_field("overflow_flag", want.fl.o, overflow_flag);
          check_field("parity_flag", want.fl.p, parity_flag);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : result_stall
    int n;
    forever begin
      n = pick_gap();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  initial begin : stimulus
    instr_row_t row;
    int gap;
    int unsigned p;

    // reset state, extremes of inc and add, start, ret and jmp are read off directly
    add_row(FUNC_NOP, KIND_REG, 0, '0, KIND_REG, 0, '0, 1,
            result_of(0, 0, '0, 0, 0, 0, 0, 0));
    add_row(FUNC_START, KIND_NONE, 0, '0, KIND_NONE, 0, MAX_SIGNED, 1,
            result_of(0, 0, MAX_SIGNED, 0, 0, 0, 0, 0));
    add_row(FUNC_INC, KIND_REG, 0, '0, KIND_NONE, 0, '0, 1,
            result_of(0, 0, MIN_SIGNED, 0, 1, 0, 1, 0));
    add_row(FUNC_DEC, KIND_REG, 0, '0, KIND_NONE, 0, '0, 0, '0);
    add_row(FUNC_START, KIND_NONE, 0, '0, KIND_NONE, 0, MIN_SIGNED, 1,
            result_of(0, 0, MIN_SIGNED, 0, 0, 0, 0, 0));
    add_row(FUNC_ADD, KIND_REG, 0, '0, KIND_IMM, 0, MIN_SIGNED, 1,
            result_of(0, 0, '0, 1, 0, 1, 1, 1));
    add_row(FUNC_RET, KIND_NONE, 0, '0, KIND_NONE, 0, '0, 1,
            result_of(0, 1, '0, 1, 0, 1, 1, 1));
    add_row(FUNC_JMP, KIND_NONE, 0, '0, KIND_NONE, 0, '0, 1,
            result_of(1, 0, '0, 1, 0, 1, 1, 1));
    add_row(FUNC_JE, KIND_NONE, 0, '0, KIND_NONE, 0, '0, 0, '0);
    add_row(FUNC_MOV, KIND_REG, 3, '0, KIND_IMM, 0, '1, 0, '0);
    add_row(FUNC_SUB, KIND_REG, 0, '0, KIND_REG, 3, '0, 0, '0);
    add_row(FUNC_MUL, KIND_REG, 0, '0, KIND_REG, 3, '0, 0, '0);
    add_row(FUNC_IMUL, KIND_REG, 3, '0, KIND_IMM, 0, MIN_SIGNED, 0, '0);
    add_row(FUNC_XOR, KIND_REG, 0, '0, KIND_IMM, 0, 64'h5a5a_a5a5_0ff0_c3c3, 0, '0);
    add_row(FUNC_AND, KIND_REG, 0, '0, KIND_REG, 3, '0, 0, '0);
    add_row(FUNC_OR, KIND_REG, 0, '0, KIND_IMM, 0, 64'h00ff, 0, '0);
    add_row(FUNC_NOT, KIND_REG, 3, '0, KIND_NONE, 0, '0, 0, '0);
    add_row(FUNC_NEG, KIND_REG, 0, '0, KIND_NONE, 0, '0, 0, '0);
    // count above 63 keeps only its low six bits
    add_row(FUNC_SHL, KIND_REG, 0, '0, KIND_IMM, 0, 64'd67, 0, '0);
    add_row(FUNC_SHR, KIND_REG, 3, '0, KIND_IMM, 0, 64'd63, 0, '0);
    add_row(FUNC_XCHG, KIND_REG, 0, '0, KIND_REG, 0, '0, 0, '0);
    add_row(FUNC_XCHG, KIND_REG, 0, '0, KIND_REG, 3, '0, 0, '0);
    add_row(FUNC_CMP, KIND_REG, 0, '0, KIND_IMM, 0, MAX_SIGNED, 0, '0);
    add_row(FUNC_JL, KIND_NONE, 0, '0, KIND_NONE, 0, '0, 0, '0);
    // immediate destination: flags move, no write
    add_row(FUNC_TEST, KIND_IMM, 0, '1, KIND_IMM, 0, 64'h80, 0, '0);
    add_row(FUNC_JNE, KIND_NONE, 0, '0, KIND_NONE, 0, '0, 0, '0);
    add_row(FUNC_JG, KIND_NONE, 0, '0, KIND_NONE, 0, '0, 0, '0);
    add_row(FUNC_JLE, KIND_NONE, 0, '0, KIND_NONE, 0, '0, 0, '0);
    add_row(FUNC_JGE, KIND_NONE, 0, '0, KIND_NONE, 0, '0, 0, '0);
    add_row(FUNC_STATEMOV, KIND_NONE, 0, '0, KIND_NONE, 0, '1, 0, '0);
    add_row(FUNC_STATECMP, KIND_NONE, 0, '0, KIND_SPARE, 0, '1, 0, '0);
    add_row(FUNC_SPARE_HI, KIND_SPARE, 0, '1, KIND_SPARE, 15, '1, 0, '0);

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    for (int n = 0; n < dir_rows.size() + RANDOM_ITEMS; n++) begin
      if (n < dir_rows.size()) begin
        row = dir_rows[n];
      end else begin
        row = '0;
        p = $urandom_range(0, 99);
        if (p < 3) row.func = FUNC_START;
        else if (p < 6) row.func = 5'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI));
        else if (p < 8) row.func = FUNC_NOP;
        else row.func = 5'($urandom_range(FUNC_MOV, FUNC_STATECMP));
        row.dk = rand_kind(80);
        row.di = rand_index();
        row.dv = rand_value();
        row.sk = rand_kind(50);
        row.si = rand_index();
        row.sv = rand_value();
      end
      if ($urandom_range(0, 99) == 0) calm = !calm;
      gap = pick_gap();
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      cur_row  <= row;
      in_valid <= 1'b1;
      do @(posedge clk); while (in_stall);
    end
    in_valid <= 1'b0;

    // let the bookkeeping of the last accepted request settle first
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
